@@ sv/reversed_digit_prime_check_macros.svh @@
// Assertion macros for the reversed digit prime checker.
// Needs clk and arst_n in the scope where a macro is used.
`ifndef REVERSED_DIGIT_PRIME_CHECK_MACROS_SVH
`define REVERSED_DIGIT_PRIME_CHECK_MACROS_SVH
`ifndef SYNTHESIS
`define RDP_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rdp check failed");
`define RDP_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rdp check failed");
`else
`define RDP_ASSERT_SAME(label, ante, cons)
`define RDP_ASSERT_NEXT(label, ante, cons)
`endif
`endif

@@ sv/rdp_check_pkg.sv @@
// Shared constants for the reversed digit prime checker.
// No dependencies.
package rdp_check_pkg;

	localparam int unsigned VALUE_BITS = 20;
	localparam int unsigned REV_OUT_BITS = 24;

	// bits needed for the reversal of any VALUE_BITS wide value
	function automatic int unsigned rev_bits_f(input int unsigned vb);
		longint unsigned m;
		longint unsigned p;
		m = (64'd1 << vb) - 64'd1;
		p = 64'd1;
		while (p <= m)
			p = p * 64'd10;
		return $clog2(p);
	endfunction

	localparam int unsigned WORK_BITS = rev_bits_f(VALUE_BITS);
	localparam int unsigned CNT_BITS = $clog2(WORK_BITS);

endpackage

@@ sv/reversed_digit_prime_check.sv @@
// Reversed digit prime checker: digit reversal and trial division primality test.
// Depends on rdp_check_pkg and reversed_digit_prime_check_macros.svh.

// One request at a time. A single restoring divider, one quotient bit per cycle,
// does all the work: one division by ten per decimal digit to build the reversal,
// then one division per trial divisor d = 2, 3, ... while d*d <= n, first for the
// value and, if it is prime, for its reversal. Each division also passes through
// a set-up state and an update state, so a request takes about digits +
// sqrt(value) + sqrt(reversal) divisions. The reversal can be far larger than
// the value: the worst case at 20 bits is a seven digit prime ending in 9 whose
// reversal, near ten million, is also prime. Composites with a small factor
// finish far sooner. in_ready is high only while the block is idle; a finished
// result waits in the output register until taken.
module reversed_digit_prime_check (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic [rdp_check_pkg::VALUE_BITS-1:0]   value,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic                                   value_is_prime,
	output logic [rdp_check_pkg::REV_OUT_BITS-1:0] reversed_value,
	output logic                                   both_prime
);

	`include "reversed_digit_prime_check_macros.svh"

	localparam int unsigned W = rdp_check_pkg::WORK_BITS;
	localparam int unsigned CW = rdp_check_pkg::CNT_BITS;

	typedef enum logic [3:0] {
		IDLE,
		REV_CHK,
		REV_UPD,
		PR_START,
		PR_CHK,
		PR_UPD,
		PR_DONE,
		DIV,
		FINISH
	} state_t;

	state_t         state_q;
	logic           ret_rev_q;   // division returns to reversal update
	logic           phase_q;     // 0: testing value, 1: testing reversal
	logic           verdict_q;
	logic           p_q;
	logic           both_q;
	logic [W-1:0]   num_q;
	logic [W-1:0]   rev_q;
	logic [W-1:0]   tgt_q;
	logic [W-1:0]   d_q;
	logic [W:0]     sq_q;
	logic [W-1:0]   dvd_q;
	logic [W-1:0]   dvs_q;
	logic [W:0]     rem_q;
	logic [CW-1:0]  cnt_q;
	logic           out_valid_q;
	logic           vip_q;
	logic           both_out_q;
	logic [W-1:0]   rev_out_q;

	// divider step
	logic [W:0] trial;
	logic       q_bit;
	logic [W:0] rem_next;
	always_comb begin
		trial = {rem_q[W-1:0], dvd_q[W-1]};
		q_bit = (trial >= {1'b0, dvs_q});
		rem_next = q_bit ? (trial - {1'b0, dvs_q}) : trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			ret_rev_q <= 1'b0;
			phase_q <= 1'b0;
			verdict_q <= 1'b0;
			p_q <= 1'b0;
			both_q <= 1'b0;
			num_q <= '0;
			rev_q <= '0;
			tgt_q <= '0;
			d_q <= '0;
			sq_q <= '0;
			dvd_q <= '0;
			dvs_q <= '0;
			rem_q <= '0;
			cnt_q <= '0;
			out_valid_q <= 1'b0;
			vip_q <= 1'b0;
			both_out_q <= 1'b0;
			rev_out_q <= '0;
		end else begin
			// FINISH owns out_valid_q in its own cycle
			if (out_valid_q && out_ready && state_q != FINISH)
				out_valid_q <= 1'b0;
			unique case (state_q)
				IDLE: begin
					if (in_valid) begin
						num_q <= W'(value);
						tgt_q <= W'(value);
						rev_q <= '0;
						phase_q <= 1'b0;
						state_q <= REV_CHK;
					end
				end
				REV_CHK: begin
					if (num_q == '0) begin
						state_q <= PR_START;
					end else begin
						dvd_q <= num_q;
						dvs_q <= W'(10);
						rem_q <= '0;
						cnt_q <= '0;
						ret_rev_q <= 1'b1;
						state_q <= DIV;
					end
				end
				DIV: begin
					dvd_q <= {dvd_q[W-2:0], q_bit};
					rem_q <= rem_next;
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CW'(W - 1))
						state_q <= ret_rev_q ? REV_UPD : PR_UPD;
				end
				REV_UPD: begin
					// rev*10 + digit; dvd now holds the quotient
					rev_q <= (rev_q << 3) + (rev_q << 1) + rem_q[W-1:0];
					num_q <= dvd_q;
					state_q <= REV_CHK;
				end
				PR_START: begin
					if (tgt_q <= W'(1)) begin
						verdict_q <= 1'b0;
						state_q <= PR_DONE;
					end else begin
						d_q <= W'(2);
						sq_q <= (W + 1)'(4);
						state_q <= PR_CHK;
					end
				end
				PR_CHK: begin
					if (sq_q > {1'b0, tgt_q}) begin
						verdict_q <= 1'b1;
						state_q <= PR_DONE;
					end else begin
						dvd_q <= tgt_q;
						dvs_q <= d_q;
						rem_q <= '0;
						cnt_q <= '0;
						ret_rev_q <= 1'b0;
						state_q <= DIV;
					end
				end
				PR_UPD: begin
					if (rem_q == '0) begin
						verdict_q <= 1'b0;
						state_q <= PR_DONE;
					end else begin
						// (d+1)^2 = d^2 + 2d + 1
						sq_q <= sq_q + {d_q, 1'b1};
						d_q <= d_q + 1'b1;
						state_q <= PR_CHK;
					end
				end
				PR_DONE: begin
					if (!phase_q) begin
						p_q <= verdict_q;
						if (verdict_q) begin
							phase_q <= 1'b1;
							tgt_q <= rev_q;
							state_q <= PR_START;
						end else begin
							both_q <= 1'b0;
							state_q <= FINISH;
						end
					end else begin
						both_q <= verdict_q;
						state_q <= FINISH;
					end
				end
				FINISH: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						vip_q <= p_q;
						both_out_q <= both_q;
						rev_out_q <= rev_q;
						state_q <= IDLE;
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

	assign in_ready = (state_q == IDLE);
	assign out_valid = out_valid_q;
	assign value_is_prime = vip_q;
	assign both_prime = both_out_q;
	assign reversed_value = rdp_check_pkg::REV_OUT_BITS'(rev_out_q);

	`RDP_ASSERT_NEXT(busy_after_accept, in_valid && in_ready, !in_ready)
	`RDP_ASSERT_SAME(both_needs_prime, out_valid && both_prime, value_is_prime)
	`RDP_ASSERT_SAME(result_from_finish, $rose(out_valid), $past(state_q == FINISH))

endmodule

@@ sim/tb_reversed_digit_prime_check.sv @@
// Self-checking testbench for reversed_digit_prime_check.
// Uses rdp_check_pkg and the RTL. A scoreboard class predicts the digit reversal
// and both primality flags by trial division for each accepted request.
module tb_reversed_digit_prime_check;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned VALUE_BITS   = rdp_check_pkg::VALUE_BITS;
	localparam int unsigned REV_OUT_BITS = rdp_check_pkg::REV_OUT_BITS;

	localparam int unsigned IDLE_LIMIT   = 1000000;
	localparam int unsigned DRAIN_CYCLES = 200;
	localparam int unsigned RANDOM_ITEMS = 100;
	localparam int unsigned QUIET_ITEMS  = 20;

	typedef struct {
		logic                    value_is_prime;
		logic [REV_OUT_BITS-1:0] reversed_value;
		logic                    both_prime;
	} emirp_result_t;

	class emirp_scoreboard;
		emirp_result_t pending_results[$];
		int unsigned   error_count;

		function new();
			error_count = 0;
		endfunction

		function longint unsigned reverse_digits(input longint unsigned n);
			longint unsigned r;
			r = 0;
			while (n != 0) begin
				r = r * 10 + n % 10;
				n = n / 10;
			end
			return r;
		endfunction

		function bit is_prime(input longint unsigned n);
			longint unsigned d;
			if (n <= 1)
				return 1'b0;
			for (d = 2; d * d <= n; d++) begin
				if (n % d == 0)
					return 1'b0;
			end
			return 1'b1;
		endfunction

		function void note_request(input logic [VALUE_BITS-1:0] v);
			longint unsigned n;
			longint unsigned r;
			emirp_result_t   res;
			n = longint'(v);
			r = reverse_digits(n);
			res.value_is_prime = is_prime(n);
			res.reversed_value = r[REV_OUT_BITS-1:0];
			// reversal is only tested when the value itself is prime
			res.both_prime = res.value_is_prime && is_prime(r);
			pending_results.push_back(res);
		endfunction

		function void check_result(input logic p, input logic [REV_OUT_BITS-1:0] rev,
				input logic both);
			emirp_result_t exp_res;
			if (pending_results.size() == 0) begin
				$error("unexpected result: value_is_prime=%0b reversed_value=%0d both_prime=%0b",
					p, rev, both);
				error_count++;
				return;
			end
			exp_res = pending_results.pop_front();
			if (p !== exp_res.value_is_prime) begin
				$error("value_is_prime: expected %0b, got %0b", exp_res.value_is_prime, p);
				error_count++;
			end
			if (rev !== exp_res.reversed_value) begin
				$error("reversed_value: expected %0d, got %0d", exp_res.reversed_value, rev);
				error_count++;
			end
			if (both !== exp_res.both_prime) begin
				$error("both_prime: expected %0b, got %0b", exp_res.both_prime, both);
				error_count++;
			end
		endfunction
	endclass

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    in_valid = 1'b0;
	logic                    in_ready;
	logic [VALUE_BITS-1:0]   value = '0;
	logic                    out_valid;
	logic                    out_ready = 1'b0;
	logic                    value_is_prime;
	logic [REV_OUT_BITS-1:0] reversed_value;
	logic                    both_prime;

	emirp_scoreboard results_sb = new();
	bit              no_idle = 1'b0;
	int unsigned     idle_cycles = 0;

	reversed_digit_prime_check i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.value         (value),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.value_is_prime(value_is_prime),
		.reversed_value(reversed_value),
		.both_prime    (both_prime)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// monitor: notes requests, checks results, counts cycles with no transfer
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				results_sb.note_request(value);
			if (out_valid && out_ready)
				results_sb.check_result(value_is_prime, reversed_value, both_prime);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		while (idle_cycles < IDLE_LIMIT)
			@(posedge clk);
		$display("DONE: errors detected");
		$finish;
	end

	// receiver back-pressure in short bursts
	initial begin
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (!no_idle && $urandom_range(0, 3) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 5)) @(negedge clk);
			end
			out_ready <= 1'b1;
			@(negedge clk);
		end
	end

	task automatic send_value(input logic [VALUE_BITS-1:0] v);
		in_valid <= 1'b1;
		value    <= v;
		do
			@(posedge clk);
		while (!in_ready);
		@(negedge clk);
	endtask

	task automatic sender_gap();
		if (!no_idle && $urandom_range(0, 2) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(negedge clk);
		end
	endtask

	// mostly small values keep the trial division short; a few span the full width
	function automatic logic [VALUE_BITS-1:0] pick_value();
		int unsigned sel;
		sel = $urandom_range(0, 19);
		if (sel < 8)
			return VALUE_BITS'($urandom_range(0, 99));
		else if (sel < 14)
			return VALUE_BITS'($urandom_range(100, 9999));
		else if (sel < 17)
			return VALUE_BITS'($urandom_range(10000, 99999));
		else
			return VALUE_BITS'($urandom_range(0, (1 << VALUE_BITS) - 1));
	endfunction

	initial begin
		int unsigned directed_values[] = '{
			0, 1, 2, 3, 4, 10, 11, 13, 23, 97, 100, 101, 130, 1000, 7331,
			524288, 1048575, 999983, 1048573, 1000003
		};
		int unsigned drain;

		arst_n = 1'b0;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed_values[k]) begin
			send_value(VALUE_BITS'(directed_values[k]));
			sender_gap();
		end

		// hold off until every outstanding result is back
		in_valid <= 1'b0;
		while (results_sb.pending_results.size() != 0)
			@(negedge clk);

		for (int unsigned k = 0; k < RANDOM_ITEMS; k++) begin
			if (k == RANDOM_ITEMS - QUIET_ITEMS)
				no_idle = 1'b1;
			send_value(pick_value());
			sender_gap();
		end
		in_valid <= 1'b0;

		while (results_sb.pending_results.size() != 0)
			@(posedge clk);
		drain = 0;
		while (drain < DRAIN_CYCLES) begin
			@(posedge clk);
			drain++;
		end

		if (results_sb.error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

@@ files.f @@
+incdir+sv
sv/rdp_check_pkg.sv
sv/reversed_digit_prime_check.sv
sim/tb_reversed_digit_prime_check.sv
